/* rtl/q2e_pkg.sv */
// shared constants, types and functions for the quaternion to euler angle pipeline
package q2e_pkg;

  localparam int CordicStagesDef = 16;
  localparam int AngTableLen = 24;
  localparam int VecW = 36;
  localparam int AngW = 28;
  localparam int SqW = 58;
  localparam int SqSteps = 29;
  localparam int RootW = 29;
  localparam logic signed [AngW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [VecW-1:0] OneQ28 = 36'sd268435456;
  localparam logic signed [15:0] RollLimit = 16'sd25736;
  localparam logic signed [14:0] PitchLimit = 15'sd12868;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } cordic_t;

  function automatic logic signed [AngW-1:0] atan_tab(input int idx);
    logic signed [AngW-1:0] r;
    begin
      case (idx)
        0: r = 28'sd13176795;
        1: r = 28'sd7778716;
        2: r = 28'sd4110060;
        3: r = 28'sd2086331;
        4: r = 28'sd1047214;
        5: r = 28'sd524117;
        6: r = 28'sd262123;
        7: r = 28'sd131069;
        default: r = (idx < AngTableLen) ? (28'sd1 <<< (24 - idx)) : 28'sd0;
      endcase
      return r;
    end
  endfunction

  // quarter turn pre-rotation, atan2(0,0) handled by the zero flag
  function automatic cordic_t cordic_pre(input logic signed [VecW-1:0] y,
                                         input logic signed [VecW-1:0] x);
    cordic_t r;
    begin
      r.x = x;
      r.y = y;
      r.z = '0;
      if (x < 0) begin
        if (y >= 0) begin
          r.x = y;
          r.y = -x;
          r.z = HalfPiQ24;
        end else begin
          r.x = -y;
          r.y = x;
          r.z = -HalfPiQ24;
        end
      end
      return r;
    end
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t r;
    logic signed [VecW-1:0] dx;
    logic signed [VecW-1:0] dy;
    begin
      dx = c.y >>> i;
      dy = c.x >>> i;
      if (c.y >= 0) begin
        r.x = c.x + dx;
        r.y = c.y - dy;
        r.z = c.z + atan_tab(i);
      end else begin
        r.x = c.x - dx;
        r.y = c.y + dy;
        r.z = c.z - atan_tab(i);
      end
      return r;
    end
  endfunction

  function automatic logic signed [15:0] ang_out(input logic signed [AngW-1:0] a,
                                                 input logic signed [15:0] lim);
    logic signed [AngW-1:0] t;
    logic signed [AngW-1:0] l;
    begin
      t = (a + 28'sd1024) >>> 11;
      l = AngW'(lim);
      if (t > l) t = l;
      if (t < -l) t = -l;
      return t[15:0];
    end
  endfunction

endpackage

/* rtl/quaternion_to_euler_angles_top.sv */
// quaternion to roll, pitch and yaw, fully pipelined cordic
// the cordic is capped at 24 stages, the length of the arctangent table
// throughput: one item per cycle, busy is always low
// pipeline: products, sums, radicand, 29 square root digit stages, pre-rotation, cordic, rounding
// reset: asynchronous active low, clears all valid bits; data registers are not reset
// the receiver cannot stall, results leave on done_o for one cycle
module quaternion_to_euler_angles_top
  import q2e_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               done_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);

  localparam int NStg = (CORDIC_STAGES < AngTableLen) ? CORDIC_STAGES : AngTableLen;

  assign busy = 1'b0;

  // stage 1: products
  logic v1_q;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, zz_q, wy_q, zx_q, wz_q, xy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    wx_q <= 32'(quat_w_i) * 32'(quat_x_i);
    yz_q <= 32'(quat_y_i) * 32'(quat_z_i);
    xx_q <= 32'(quat_x_i) * 32'(quat_x_i);
    yy_q <= 32'(quat_y_i) * 32'(quat_y_i);
    zz_q <= 32'(quat_z_i) * 32'(quat_z_i);
    wy_q <= 32'(quat_w_i) * 32'(quat_y_i);
    zx_q <= 32'(quat_z_i) * 32'(quat_x_i);
    wz_q <= 32'(quat_w_i) * 32'(quat_z_i);
    xy_q <= 32'(quat_x_i) * 32'(quat_y_i);
  end

  // stage 2: atan2 arguments and clamped sine
  logic v2_q;
  logic signed [VecW-1:0] rn_q, rd_q, yn_q, yd_q, s_q;
  logic signed [VecW-1:0] s_d;
  always_comb begin
    s_d = 36'sd2 * (VecW'(wy_q) - VecW'(zx_q));
    if (s_d > OneQ28) s_d = OneQ28;
    if (s_d < -OneQ28) s_d = -OneQ28;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    rn_q <= 36'sd2 * (VecW'(wx_q) + VecW'(yz_q));
    rd_q <= OneQ28 - 36'sd2 * (VecW'(xx_q) + VecW'(yy_q));
    yn_q <= 36'sd2 * (VecW'(wz_q) + VecW'(xy_q));
    yd_q <= OneQ28 - 36'sd2 * (VecW'(yy_q) + VecW'(zz_q));
    s_q  <= s_d;
  end

  // stage 3: radicand 1 - s^2 in q56
  logic v3_q;
  logic [SqW-1:0] rad_q;
  logic signed [VecW-1:0] rn3_q, rd3_q, yn3_q, yd3_q, s3_q;
  logic [29:0] sabs;
  logic [59:0] ssq;
  assign sabs = s_q[VecW-1] ? 30'(-s_q) : 30'(s_q);
  assign ssq = 60'(sabs) * 60'(sabs);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    rad_q <= SqW'((60'd1 << 56) - ssq);
    rn3_q <= rn_q;
    rd3_q <= rd_q;
    yn3_q <= yn_q;
    yd3_q <= yd_q;
    s3_q  <= s_q;
  end

  // square root, one digit per stage
  logic [SqW-1:0] sq_rem_q [SqSteps+1];
  logic [RootW-1:0] sq_root_q [SqSteps+1];
  logic signed [VecW-1:0] sq_rn_q [SqSteps+1];
  logic signed [VecW-1:0] sq_rd_q [SqSteps+1];
  logic signed [VecW-1:0] sq_yn_q [SqSteps+1];
  logic signed [VecW-1:0] sq_yd_q [SqSteps+1];
  logic signed [VecW-1:0] sq_s_q [SqSteps+1];
  logic sq_v_q [SqSteps+1];

  always_comb begin
    sq_rem_q[0] = rad_q;
    sq_root_q[0] = '0;
    sq_rn_q[0] = rn3_q;
    sq_rd_q[0] = rd3_q;
    sq_yn_q[0] = yn3_q;
    sq_yd_q[0] = yd3_q;
    sq_s_q[0] = s3_q;
    sq_v_q[0] = v3_q;
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam int Sh = 2 * (SqSteps - 1 - k);
    logic [SqW+1:0] trial;
    logic [SqW+1:0] remw;
    assign trial = ({2'b0, (SqW'(sq_root_q[k]) << 2)} | 60'd1) << Sh;
    assign remw = {2'b0, sq_rem_q[k]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k+1] <= 1'b0;
      else sq_v_q[k+1] <= sq_v_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (remw >= trial) begin
        sq_rem_q[k+1] <= SqW'(remw - trial);
        sq_root_q[k+1] <= {sq_root_q[k][RootW-2:0], 1'b1};
      end else begin
        sq_rem_q[k+1] <= sq_rem_q[k];
        sq_root_q[k+1] <= {sq_root_q[k][RootW-2:0], 1'b0};
      end
      sq_rn_q[k+1] <= sq_rn_q[k];
      sq_rd_q[k+1] <= sq_rd_q[k];
      sq_yn_q[k+1] <= sq_yn_q[k];
      sq_yd_q[k+1] <= sq_yd_q[k];
      sq_s_q[k+1] <= sq_s_q[k];
    end
  end

  // pre-rotation stage
  cordic_t cr_q [NStg+1];
  cordic_t cp_q [NStg+1];
  cordic_t cy_q [NStg+1];
  logic cv_q [NStg+1];
  logic zr_q, zy_q;
  logic signed [VecW-1:0] c_arg;
  assign c_arg = VecW'(sq_root_q[SqSteps]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q[0] <= 1'b0;
    else cv_q[0] <= sq_v_q[SqSteps];
  end
  always_ff @(posedge clk_i) begin
    cr_q[0] <= cordic_pre(sq_rn_q[SqSteps], sq_rd_q[SqSteps]);
    cp_q[0] <= cordic_pre(sq_s_q[SqSteps], c_arg);
    cy_q[0] <= cordic_pre(sq_yn_q[SqSteps], sq_yd_q[SqSteps]);
  end

  // zero flags travel with the cordic stages
  logic zrp_q [NStg+1];
  logic zyp_q [NStg+1];
  always_ff @(posedge clk_i) begin
    zrp_q[0] <= (sq_rn_q[SqSteps] == '0) && (sq_rd_q[SqSteps] == '0);
    zyp_q[0] <= (sq_yn_q[SqSteps] == '0) && (sq_yd_q[SqSteps] == '0);
  end

  for (genvar i = 0; i < NStg; i++) begin : g_cordic
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i+1] <= 1'b0;
      else cv_q[i+1] <= cv_q[i];
    end
    always_ff @(posedge clk_i) begin
      cr_q[i+1] <= cordic_step(cr_q[i], i);
      cp_q[i+1] <= cordic_step(cp_q[i], i);
      cy_q[i+1] <= cordic_step(cy_q[i], i);
      zrp_q[i+1] <= zrp_q[i];
      zyp_q[i+1] <= zyp_q[i];
    end
  end

  assign zr_q = zrp_q[NStg];
  assign zy_q = zyp_q[NStg];

  // output rounding and saturation
  logic done_q;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic signed [15:0] pitch_full;
  assign pitch_full = ang_out(cp_q[NStg].z, 16'(PitchLimit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= cv_q[NStg];
  end
  always_ff @(posedge clk_i) begin
    roll_q  <= zr_q ? '0 : ang_out(cr_q[NStg].z, RollLimit);
    pitch_q <= pitch_full[14:0];
    yaw_q   <= zy_q ? '0 : ang_out(cy_q[NStg].z, RollLimit);
  end

  assign done_o = done_q;
  assign roll_angle_o = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o = yaw_q;

  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_pitch_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_angle_o <= PitchLimit && pitch_angle_o >= -PitchLimit))
    else $error("pitch out of range");
  a_roll_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_angle_o <= RollLimit && roll_angle_o >= -RollLimit))
    else $error("roll out of range");
  a_sqrt_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ##(SqSteps + NStg + 2) done_o)
    else $error("item lost in pipeline");

endmodule

/* tb/sv/quaternion_to_euler_angles_checker.sv */
// checker: predicts roll, pitch and yaw for each accepted item and compares results
module quaternion_to_euler_angles_checker
  import q2e_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic               done_o,
  input  logic signed [15:0] roll_angle_o,
  input  logic signed [14:0] pitch_angle_o,
  input  logic signed [15:0] yaw_angle_o,
  output int                 fails_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  localparam longint OneQ28L = 64'sd1 << 28;
  localparam longint HalfPiL = 64'sd26353589;

  euler_t angles_due[$];

  function automatic longint atan_q24(int i);
    longint t[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
    if (i < 8) return t[i];
    return 64'sd1 << (24 - i);
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint ang;
    longint tx;
    longint dx;
    longint dy;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      tx = xv;
      if (yv >= 0) begin
        xv = yv; yv = -tx; ang = HalfPiL;
      end else begin
        xv = -yv; yv = tx; ang = -HalfPiL;
      end
    end
    for (int i = 0; i < CordicStagesDef && i < AngTableLen; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; ang += atan_q24(i);
      end else begin
        xv -= dx; yv += dy; ang -= atan_q24(i);
      end
    end
    return ang;
  endfunction

  function automatic longint to_q13_sat(longint a, longint lim);
    longint t;
    t = (a + 1024) >>> 11;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic euler_t quat_to_euler(longint w, longint x, longint y, longint z);
    euler_t r;
    longint s;
    longint c;
    r.roll = 16'(to_q13_sat(vector_angle(2 * (w * x + y * z),
                                         OneQ28L - 2 * (x * x + y * y)), 25736));
    s = 2 * (w * y - z * x);
    if (s > OneQ28L) s = OneQ28L;
    if (s < -OneQ28L) s = -OneQ28L;
    c = longint'(root_floor((64'd1 << 56) - 64'(s * s)));
    r.pitch = 15'(to_q13_sat(vector_angle(s, c), 12868));
    r.yaw = 16'(to_q13_sat(vector_angle(2 * (w * z + x * y),
                                        OneQ28L - 2 * (y * y + z * z)), 25736));
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails_o++;
  endtask

  initial fails_o = 0;
  assign pending_o = angles_due.size();

  always @(posedge clk_i) begin
    euler_t want;
    if (rst_ni) begin
      if (start && !busy)
        angles_due.insert(angles_due.size(),
                          quat_to_euler(quat_w_i, quat_x_i, quat_y_i, quat_z_i));
      if (done_o) begin
        if (angles_due.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          want = angles_due.pop_front();
          if (roll_angle_o !== want.roll)
            report_mismatch($sformatf("roll %0d want %0d", roll_angle_o, want.roll));
          if (pitch_angle_o !== want.pitch)
            report_mismatch($sformatf("pitch %0d want %0d", pitch_angle_o, want.pitch));
          if (yaw_angle_o !== want.yaw)
            report_mismatch($sformatf("yaw %0d want %0d", yaw_angle_o, want.yaw));
        end
      end
    end
  end
endmodule

/* tb/sv/quaternion_to_euler_angles_top_test.sv */
// testbench top: drives quaternions into the converter and reports the verdict
module quaternion_to_euler_angles_top_test;
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic               done_o;
  logic signed [15:0] roll_angle_o;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;
  int                 fails;
  int                 pending;

  always #6 clk_i = ~clk_i;

  quaternion_to_euler_angles_top dut (.*);

  quaternion_to_euler_angles_checker chk (
    .*, .fails_o(fails), .pending_o(pending)
  );

  task automatic send_quat(int w, int x, int y, int z, int may_idle);
    if (may_idle != 0 && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    start <= 1'b1;
    quat_w_i <= 16'(w);
    quat_x_i <= 16'(x);
    quat_y_i <= 16'(y);
    quat_z_i <= 16'(z);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_part(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($signed($urandom_range(0, 23170)) - 11585);
    endcase
  endfunction

  initial begin
    int mode;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // identity, zero, extremes, quarter turns, atan2 of zero and negative x
    send_quat(16384, 0, 0, 0, 0);
    send_quat(0, 0, 0, 0, 0);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
    send_quat(0, 16384, 0, 0, 0);
    send_quat(0, 0, 16384, 0, 0);
    send_quat(0, 0, 0, 16384, 0);
    send_quat(11585, 11585, 0, 0, 0);
    send_quat(11585, 0, 11585, 0, 0);
    send_quat(11585, 0, -11585, 0, 0);
    send_quat(11585, 0, 0, -11585, 0);
    send_quat(-11585, 11585, 0, 0, 0);
    send_quat(8192, 8192, 8192, 8192, 0);
    send_quat(8192, -8192, 8192, -8192, 0);
    send_quat(0, 16384, 16384, 0, 0);
    send_quat(16384, 0, 16384, 0, 0);
    send_quat(16384, 0, -16384, 0, 0);
    send_quat(-32768, 0, 32767, 0, 0);
    send_quat(1, -1, 1, -1, 0);
    send_quat(0, 11585, 0, -11585, 0);
    for (int n = 0; n < 1900; n++) begin
      mode = $urandom_range(0, 3);
      send_quat(pick_part(mode), pick_part(mode), pick_part(mode), pick_part(mode),
                n < 1700);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
